@@ rtl/tsc_pkg.sv @@
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int TERMS     = 10;
  localparam int FRAC_BITS = 28;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int CHUNK_W = 32;
  localparam int RECIP_W = 32;
  localparam int T_W     = 59;
  localparam int SUM_W   = 64;
  localparam int X2_W    = 63 - FRAC_BITS;
  localparam int B_W     = (X2_W > RECIP_W) ? X2_W : RECIP_W;
  localparam int P_W     = CHUNK_W + B_W;
  localparam int ACC_W   = T_W + B_W + 1;
  localparam int M_W     = $clog2(2 * TERMS);
  localparam int N_W     = $clog2(TERMS + 1);
  localparam int RECIP_N = 32;
  localparam int RIDX_W  = 5;

  localparam logic [T_W-1:0] MAG_MAX = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [63:0]    RONE    = 64'd1 << 32;

  // reciprocal of (m+1)(m+2) with 32 fraction bits, rounded, indexed by m
  localparam logic [RECIP_W-1:0] RECIP_TAB [RECIP_N] = '{
    32'((RONE + 64'd1)   / 64'd2),
    32'((RONE + 64'd3)   / 64'd6),
    32'((RONE + 64'd6)   / 64'd12),
    32'((RONE + 64'd10)  / 64'd20),
    32'((RONE + 64'd15)  / 64'd30),
    32'((RONE + 64'd21)  / 64'd42),
    32'((RONE + 64'd28)  / 64'd56),
    32'((RONE + 64'd36)  / 64'd72),
    32'((RONE + 64'd45)  / 64'd90),
    32'((RONE + 64'd55)  / 64'd110),
    32'((RONE + 64'd66)  / 64'd132),
    32'((RONE + 64'd78)  / 64'd156),
    32'((RONE + 64'd91)  / 64'd182),
    32'((RONE + 64'd105) / 64'd210),
    32'((RONE + 64'd120) / 64'd240),
    32'((RONE + 64'd136) / 64'd272),
    32'((RONE + 64'd153) / 64'd306),
    32'((RONE + 64'd171) / 64'd342),
    32'((RONE + 64'd190) / 64'd380),
    32'((RONE + 64'd210) / 64'd420),
    32'((RONE + 64'd231) / 64'd462),
    32'((RONE + 64'd253) / 64'd506),
    32'((RONE + 64'd276) / 64'd552),
    32'((RONE + 64'd300) / 64'd600),
    32'((RONE + 64'd325) / 64'd650),
    32'((RONE + 64'd351) / 64'd702),
    32'((RONE + 64'd378) / 64'd756),
    32'((RONE + 64'd406) / 64'd812),
    32'((RONE + 64'd435) / 64'd870),
    32'((RONE + 64'd465) / 64'd930),
    32'((RONE + 64'd496) / 64'd992),
    32'((RONE + 64'd528) / 64'd1056)
  };

  typedef enum logic [1:0] {
    A_MAG  = 2'd0,
    A_T_LO = 2'd1,
    A_T_HI = 2'd2
  } a_sel_t;

  typedef enum logic [1:0] {
    B_MAG   = 2'd0,
    B_X2    = 2'd1,
    B_RECIP = 2'd2
  } b_sel_t;

  typedef enum logic [1:0] {
    MODE_X2  = 2'd0,
    MODE_TX2 = 2'd1,
    MODE_TRC = 2'd2
  } mode_t;

  typedef struct packed {
    logic   load;
    logic   issue;
    logic   start;
    a_sel_t a_sel;
    b_sel_t b_sel;
    mode_t  mode;
    logic   finish;
    logic   add_term;
    logic   latch_out;
  } tsc_cmd_t;

  typedef struct packed {
    logic t_hi_zero;
  } tsc_sts_t;

endpackage

@@ rtl/taylor_sine_cosine.sv @@
// Each series step forms two products on one shared 32 x 35 multiplier, the term times x^2
//   and then times the reciprocal, and adds a second pass to either product whose term has
//   bits set above its low 32 bits.
// One item at a time: the next item is taken once the result is registered and the
//   controller is idle again, while that result may still wait in the output register.
// Reset: synchronous, active low; clears the controller state, out_valid and product valid.
`timescale 1ns / 1ps

module taylor_sine_cosine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tsc_pkg::VALUE_W-1:0] out_value,
  output logic                               out_saturated
);
  import tsc_pkg::*;

  tsc_cmd_t cmd;
  tsc_sts_t sts;

  tsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsc_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_angle      (in_angle),
    .sts           (sts),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

endmodule

@@ rtl/tsc_dpath.sv @@
`timescale 1ns / 1ps

module tsc_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsc_pkg::tsc_cmd_t              cmd,
  input  logic                           in_operation,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
  output tsc_pkg::tsc_sts_t              sts,
  output logic signed [tsc_pkg::VALUE_W-1:0] out_value,
  output logic                           out_saturated
);
  import tsc_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] POS_LIM = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] NEG_LIM = {1'b1, {(VALUE_W-1){1'b0}}};

  logic [ANGLE_W-1:0] angle_u;
  logic               xneg;
  logic [ANGLE_W-1:0] mag_in;

  logic [ANGLE_W-1:0] mag_r;
  logic [X2_W-1:0]    x2_r;
  logic [T_W-1:0]     t_r;
  logic               neg_r;
  logic [M_W-1:0]     m_r;
  logic [SUM_W-1:0]   sum_r;
  logic               ovf_r;
  mode_t              mode_r;
  logic [P_W-1:0]     prod_r;
  logic               hi_r;
  logic               pp_v_r;
  logic [ACC_W-1:0]   acc_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic               out_sat_r;

  logic [CHUNK_W-1:0] a_op;
  logic [B_W-1:0]     b_op;
  logic [P_W-1:0]     prod_nxt;
  logic [ACC_W-1:0]   acc_add;
  logic [ACC_W-1:0]   acc_half;
  logic [ACC_W-1:0]   q;
  logic               q_big;
  logic [T_W-1:0]     t_new;
  logic [SUM_W-1:0]   term;
  logic [VALUE_W-1:0] val_nxt;
  logic               sat_nxt;

  assign angle_u = in_angle;
  assign xneg    = angle_u[ANGLE_W-1];
  assign mag_in  = xneg ? (~angle_u + ANGLE_W'(1)) : angle_u;

  always_comb begin
    unique case (cmd.a_sel)
      A_MAG:   a_op = mag_r;
      A_T_LO:  a_op = t_r[CHUNK_W-1:0];
      A_T_HI:  a_op = CHUNK_W'(t_r[T_W-1:CHUNK_W]);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.b_sel)
      B_MAG:   b_op = B_W'(mag_r);
      B_X2:    b_op = B_W'(x2_r);
      B_RECIP: b_op = B_W'(RECIP_TAB[RIDX_W'(m_r)]);
      default: b_op = '0;
    endcase
  end

  assign prod_nxt = P_W'(a_op) * P_W'(b_op);

  assign acc_add = acc_r + (hi_r ? (ACC_W'(prod_r) << CHUNK_W) : ACC_W'(prod_r));

  always_comb begin
    unique case (cmd.mode)
      MODE_TRC: acc_half = ACC_W'(1) << (RECIP_W - 1);
      default:  acc_half = ACC_W'(1) << (FRAC_BITS - 1);
    endcase
  end

  assign q     = (mode_r == MODE_TRC) ? (acc_add >> RECIP_W) : (acc_add >> FRAC_BITS);
  assign q_big = q > ACC_W'(MAG_MAX);
  assign t_new = q_big ? MAG_MAX : T_W'(q);
  assign term  = SUM_W'(t_r);

  always_comb begin
    priority if (ovf_r) begin
      val_nxt = $signed(sum_r) < 0 ? NEG_LIM : POS_LIM;
      sat_nxt = 1'b1;
    end else if ($signed(sum_r) > $signed(SUM_MAX)) begin
      val_nxt = POS_LIM;
      sat_nxt = 1'b1;
    end else if ($signed(sum_r) < $signed(SUM_MIN)) begin
      val_nxt = NEG_LIM;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = sum_r[VALUE_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_in;
      sum_r <= '0;
      ovf_r <= 1'b0;
      if (in_operation) begin
        t_r   <= T_W'(1) << FRAC_BITS;
        neg_r <= 1'b0;
        m_r   <= '0;
      end else begin
        t_r   <= T_W'(mag_in);
        neg_r <= xneg;
        m_r   <= M_W'(1);
      end
    end
    if (cmd.issue) begin
      prod_r <= prod_nxt;
      hi_r   <= (cmd.a_sel == A_T_HI);
    end
    if (cmd.start) begin
      acc_r  <= acc_half;
      mode_r <= cmd.mode;
    end else if (pp_v_r) begin
      acc_r <= acc_add;
    end
    if (cmd.add_term) begin
      sum_r <= neg_r ? (sum_r - term) : (sum_r + term);
    end
    if (cmd.finish) begin
      unique case (mode_r)
        MODE_X2: begin
          x2_r <= X2_W'(q);
        end
        MODE_TX2: begin
          t_r <= t_new;
          if (q_big) ovf_r <= 1'b1;
        end
        MODE_TRC: begin
          t_r   <= t_new;
          neg_r <= ~neg_r;
          m_r   <= m_r + M_W'(2);
          if (q_big) ovf_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.latch_out) begin
      out_value_r <= val_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign sts.t_hi_zero = (t_r[T_W-1:CHUNK_W] == '0);
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

@@ rtl/tsc_ctrl.sv @@
`timescale 1ns / 1ps

module tsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tsc_pkg::tsc_sts_t  sts,
  output tsc_pkg::tsc_cmd_t  cmd
);
  import tsc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_X2_ISSUE  = 11'b000_0000_0010,
    S_X2_DRAIN  = 11'b000_0000_0100,
    S_TX2_LO    = 11'b000_0000_1000,
    S_TX2_HI    = 11'b000_0001_0000,
    S_TX2_DRAIN = 11'b000_0010_0000,
    S_TRC_LO    = 11'b000_0100_0000,
    S_TRC_HI    = 11'b000_1000_0000,
    S_TRC_DRAIN = 11'b001_0000_0000,
    S_LAST      = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  localparam logic [N_W-1:0] N_LAST = N_W'(TERMS - 2);

  state_t         state_r, state_nxt;
  logic [N_W-1:0] n_r, n_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_X2_ISSUE;
        end
      end
      S_X2_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.start = 1'b1;
        cmd.a_sel = A_MAG;
        cmd.b_sel = B_MAG;
        cmd.mode  = MODE_X2;
        state_nxt = S_X2_DRAIN;
      end
      S_X2_DRAIN: begin
        cmd.finish = 1'b1;
        n_nxt      = '0;
        state_nxt  = (TERMS > 1) ? S_TX2_LO : S_LAST;
      end
      S_TX2_LO: begin
        cmd.add_term = 1'b1;
        cmd.issue    = 1'b1;
        cmd.start    = 1'b1;
        cmd.a_sel    = A_T_LO;
        cmd.b_sel    = B_X2;
        cmd.mode     = MODE_TX2;
        state_nxt    = sts.t_hi_zero ? S_TX2_DRAIN : S_TX2_HI;
      end
      S_TX2_HI: begin
        cmd.issue = 1'b1;
        cmd.a_sel = A_T_HI;
        cmd.b_sel = B_X2;
        state_nxt = S_TX2_DRAIN;
      end
      S_TX2_DRAIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_TRC_LO;
      end
      S_TRC_LO: begin
        cmd.issue = 1'b1;
        cmd.start = 1'b1;
        cmd.a_sel = A_T_LO;
        cmd.b_sel = B_RECIP;
        cmd.mode  = MODE_TRC;
        state_nxt = sts.t_hi_zero ? S_TRC_DRAIN : S_TRC_HI;
      end
      S_TRC_HI: begin
        cmd.issue = 1'b1;
        cmd.a_sel = A_T_HI;
        cmd.b_sel = B_RECIP;
        state_nxt = S_TRC_DRAIN;
      end
      S_TRC_DRAIN: begin
        cmd.finish = 1'b1;
        n_nxt      = n_r + N_W'(1);
        state_nxt  = (n_r == N_LAST) ? S_LAST : S_TX2_LO;
      end
      S_LAST: begin
        cmd.add_term = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.latch_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ tb/taylor_sine_cosine_tb.sv @@
`timescale 1ns / 1ps

module taylor_sine_cosine_tb;

  localparam int ANG_W        = tsc_pkg::ANGLE_W;
  localparam int VAL_W        = tsc_pkg::VALUE_W;
  localparam int FRAC         = tsc_pkg::FRAC_BITS;
  localparam int NUM_TERMS    = tsc_pkg::TERMS;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 2000;

  localparam logic [63:0] TERM_CAP = 64'd1 << 58;
  localparam logic signed [63:0] SUM_HI = 64'sd2147483647;
  localparam logic signed [63:0] SUM_LO = -64'sd2147483648;

  localparam logic [ANG_W-1:0] ONE_Q       = 32'd1 << FRAC;
  localparam logic [ANG_W-1:0] ANG_HALF_PI = 32'd421657428;
  localparam logic [ANG_W-1:0] ANG_PI      = 32'd843314857;
  localparam logic [ANG_W-1:0] ANG_TWO_PI  = 32'd1686629713;

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } series_t;

  typedef struct packed {
    op_e              op;
    logic [ANG_W-1:0] angle;
    bit               known;
    logic [VAL_W-1:0] value;
    logic             saturated;
  } vector_t;

  localparam int N_DIRECTED = 24;
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{OP_SINE,   32'd0,         1'b1, 32'd0,         1'b0},
    '{OP_COSINE, 32'd0,         1'b1, ONE_Q,         1'b0},
    '{OP_SINE,   32'd1,         1'b1, 32'd1,         1'b0},
    '{OP_SINE,   32'hFFFFFFFF,  1'b1, 32'hFFFFFFFF,  1'b0},
    '{OP_COSINE, 32'd1,         1'b1, ONE_Q,         1'b0},
    '{OP_COSINE, 32'hFFFFFFFF,  1'b1, ONE_Q,         1'b0},
    '{OP_SINE,   32'h7FFFFFFF,  1'b0, 32'd0,         1'b0},
    '{OP_COSINE, 32'h7FFFFFFF,  1'b0, 32'd0,         1'b0},
    '{OP_SINE,   32'h80000000,  1'b0, 32'd0,         1'b0},
    '{OP_COSINE, 32'h80000000,  1'b0, 32'd0,         1'b0},
    '{OP_SINE,   ANG_HALF_PI,   1'b0, 32'd0,         1'b0},
    '{OP_SINE,   -ANG_HALF_PI,  1'b0, 32'd0,         1'b0},
    '{OP_COSINE, ANG_HALF_PI,   1'b0, 32'd0,         1'b0},
    '{OP_COSINE, -ANG_HALF_PI,  1'b0, 32'd0,         1'b0},
    '{OP_SINE,   ANG_PI,        1'b0, 32'd0,         1'b0},
    '{OP_SINE,   -ANG_PI,       1'b0, 32'd0,         1'b0},
    '{OP_COSINE, ANG_PI,        1'b0, 32'd0,         1'b0},
    '{OP_COSINE, -ANG_PI,       1'b0, 32'd0,         1'b0},
    '{OP_SINE,   ANG_TWO_PI,    1'b0, 32'd0,         1'b0},
    '{OP_COSINE, ANG_TWO_PI,    1'b0, 32'd0,         1'b0},
    '{OP_SINE,   32'h55555555,  1'b0, 32'd0,         1'b0},
    '{OP_COSINE, 32'hAAAAAAAA,  1'b0, 32'd0,         1'b0},
    '{OP_SINE,   32'h10000000,  1'b0, 32'd0,         1'b0},
    '{OP_COSINE, 32'h10000000,  1'b0, 32'd0,         1'b0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_operation;
  logic signed [ANG_W-1:0] in_angle;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_saturated;

  series_t     pending_sums[$];
  logic        quiet;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned cosine_sent;
  int unsigned results_seen;
  int unsigned clipped_seen;
  int unsigned idle_cycles;

  taylor_sine_cosine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // round half up of a*b / 2^s, held at the term cap
  function automatic logic [63:0] scale_term(input logic [63:0] a, input logic [63:0] b,
                                             input int s, inout logic ovf);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = (prod + (128'd1 << (s - 1))) >> s;
    if (prod > {64'd0, TERM_CAP}) begin
      ovf = 1'b1;
      return TERM_CAP;
    end
    return prod[63:0];
  endfunction

  function automatic series_t series_sum(input op_e op, input logic [ANG_W-1:0] angle);
    logic              xneg;
    logic [63:0]       mag;
    logic [63:0]       x2;
    logic [63:0]       t;
    logic [63:0]       d;
    logic [63:0]       recip;
    logic              neg;
    logic              ovf;
    logic signed [63:0] acc;
    int                m;
    series_t           r;
    xneg = angle[ANG_W-1];
    mag  = xneg ? {32'd0, ~angle + 32'd1} : {32'd0, angle};
    x2   = (mag * mag + (64'd1 << (FRAC - 1))) >> FRAC;
    ovf  = 1'b0;
    acc  = '0;
    if (op == OP_COSINE) begin
      t   = 64'd1 << FRAC;
      neg = 1'b0;
      m   = 0;
    end else begin
      t   = mag;
      neg = xneg;
      m   = 1;
    end
    for (int n = 0; n < NUM_TERMS; n++) begin
      if (neg) acc = acc - $signed(t);
      else     acc = acc + $signed(t);
      if (n + 1 < NUM_TERMS) begin
        d     = 64'((m + 1) * (m + 2));
        recip = ((64'd1 << 32) + d / 64'd2) / d;
        t     = scale_term(t, x2, FRAC, ovf);
        t     = scale_term(t, recip, 32, ovf);
        neg   = ~neg;
        m     = m + 2;
      end
    end
    r.saturated = 1'b1;
    if (ovf) begin
      r.value = (acc < 0) ? SUM_LO[VAL_W-1:0] : SUM_HI[VAL_W-1:0];
    end else if (acc > SUM_HI) begin
      r.value = SUM_HI[VAL_W-1:0];
    end else if (acc < SUM_LO) begin
      r.value = SUM_LO[VAL_W-1:0];
    end else begin
      r.value     = acc[VAL_W-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic [ANG_W-1:0] draw_angle();
    int unsigned      sel;
    logic [ANG_W-1:0] raw;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      raw = 32'($urandom_range(0, 2 * ANG_PI)) - ANG_PI;
    end else if (sel < 70) begin
      raw = $urandom;
    end else if (sel < 85) begin
      raw = $urandom_range(0, 4095);
      raw = $urandom_range(0, 1) ? 32'h7FFFFFFF - raw : 32'h80000000 + raw;
    end else begin
      raw = $urandom >> $urandom_range(8, 31);
      if ($urandom_range(0, 1)) raw = -raw;
    end
    return raw;
  endfunction

  task automatic send_angle(input op_e op, input logic [ANG_W-1:0] angle,
                            input bit known, input series_t typed);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_angle     <= angle;
    do @(posedge clk); while (!in_ready);
    pending_sums.push_back(known ? typed : series_sum(op, angle));
    items_sent++;
    if (op == OP_COSINE) cosine_sent++;
  endtask

  task automatic check_result();
    series_t want;
    results_seen++;
    if (out_saturated === 1'b1) clipped_seen++;
    if (pending_sums.size() == 0) begin
      $error("result with nothing pending: value %0d saturated %0b", out_value, out_saturated);
      fail_count++;
    end else begin
      want = pending_sums.pop_front();
      if (out_value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, out_value);
        fail_count++;
      end
      if (out_saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
        fail_count++;
      end
    end
  endtask

  // result side: random stalls, plus two long hold-offs while the input keeps offering
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen == 60 || results_seen == 400) stall = HOLD_CYCLES;
      else stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    series_t typed;
    fail_count   = 0;
    items_sent   = 0;
    cosine_sent  = 0;
    results_seen = 0;
    clipped_seen = 0;
    idle_cycles  = 0;
    quiet        <= 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= 1'b0;
    in_angle     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      typed.value     = DIRECTED[i].value;
      typed.saturated = DIRECTED[i].saturated;
      send_angle(DIRECTED[i].op, DIRECTED[i].angle, DIRECTED[i].known, typed);
    end

    typed = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) quiet <= ($urandom_range(0, 3) == 0);
      send_angle(op_e'($urandom_range(0, 1)), draw_angle(), 1'b0, typed);
    end
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d angles (%0d cosine, %0d sine); %0d results checked, %0d clipped.",
             items_sent, cosine_sent, items_sent - cosine_sent, results_seen, clipped_seen);
    $display("Result side stalled at random and held off twice for %0d cycles.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tsc_pkg.sv
rtl/tsc_dpath.sv
rtl/tsc_ctrl.sv
rtl/taylor_sine_cosine.sv
tb/taylor_sine_cosine_tb.sv
